@@ design/arm_pkg.sv @@
// Package for the axis rotation matrix unit: payload structs, CORDIC word
// widths, fixed-point constants and the arctangent table.
// No dependencies.
`default_nettype none

package arm_pkg;

  localparam int CORDIC_STAGES = 16;            // 8 .. 24
  localparam int IDXW          = $clog2(CORDIC_STAGES);
  localparam int XW            = 34;            // x, y datapath, Q2.30 plus headroom
  localparam int ZW            = 35;            // residual angle, Q2.30 over +-8 rad

  localparam logic [1:0] CMD_X        = 2'd0;
  localparam logic [1:0] CMD_Y        = 2'd1;
  localparam logic [1:0] CMD_Z        = 2'd2;
  localparam logic [1:0] CMD_IDENTITY = 2'd3;

  localparam logic signed [ZW-1:0] HALF_PI_Q30  = 35'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30       = 35'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30   = 35'sd6746518852;
  localparam logic signed [XW-1:0] GAIN_INV_Q30 = 34'sd652032874;

  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [15:0] ZERO_Q14    = 16'sd0;
  localparam logic signed [15:0] NEG_ONE_Q14 = -16'sd16384;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_t;

  // Working word handed from cell to cell.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
    logic [1:0]           cmd;
  } cordic_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({{(ZW-32){1'b0}}, v});
  endfunction

endpackage

`default_nettype wire

@@ design/axis_rotation_matrix_unit.sv @@
// Axis rotation matrix unit: 3x3 elementary rotation about X, Y or Z.
// Registered stages in order: reduce, the CORDIC cells, output.
// Throughput: one transaction per cycle while out_stall_i is low; every stage register has its own
// valid and collapses bubbles, so input is taken while a result waits.
// Reset: rst_ni asynchronous, active low, clears all stage valids only.
// Depends on arm_pkg, arm_reduce, arm_cordic_cell, arm_matrix.
`default_nettype none

module axis_rotation_matrix_unit (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  arm_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output arm_pkg::out_t  out_data_o
);
  import arm_pkg::*;

  // Link k feeds cell k; link CORDIC_STAGES feeds the output stage.
  cordic_t chain_data  [CORDIC_STAGES+1];
  logic    chain_valid [CORDIC_STAGES+1];
  logic    chain_ready [CORDIC_STAGES+1];
  logic    in_ready;

  assign in_stall_o = !in_ready;

  // Range reduction into -pi/2..pi/2, with fold flag
  arm_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .data_i  (in_data_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  // Row of CORDIC cells, one iteration each
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    arm_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (IDXW'(k)),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // Rounding, fold and matrix placement; holds the result transaction
  arm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[CORDIC_STAGES]),
    .ready_o (chain_ready[CORDIC_STAGES]),
    .data_i  (chain_data[CORDIC_STAGES]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ design/arm_reduce.sv @@
// Input stage: widens the angle to Q2.30, folds it into -pi/2..pi/2 and
// seeds the CORDIC word. Depends on arm_pkg.
`default_nettype none

module arm_reduce (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            valid_i,
  output logic           ready_o,
  input  arm_pkg::in_t   data_i,
  output logic           valid_o,
  input  wire            ready_i,
  output arm_pkg::cordic_t data_o
);
  import arm_pkg::*;

  logic             valid_q;
  cordic_t          data_d, data_q;
  logic signed [ZW-1:0] z0, z1;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    z0 = $signed({{(ZW-34){data_i.angle[15]}}, data_i.angle, 18'b0});
    priority if (z0 > PI_Q30) begin
      z1 = z0 - TWO_PI_Q30;
    end else if (z0 < -PI_Q30) begin
      z1 = z0 + TWO_PI_Q30;
    end else begin
      z1 = z0;
    end
    data_d.x    = GAIN_INV_Q30;
    data_d.y    = '0;
    data_d.cmd  = data_i.cmd;
    priority if (z1 > HALF_PI_Q30) begin
      data_d.z    = z1 - PI_Q30;
      data_d.flip = 1'b1;
    end else if (z1 < -HALF_PI_Q30) begin
      data_d.z    = z1 + PI_Q30;
      data_d.flip = 1'b1;
    end else begin
      data_d.z    = z1;
      data_d.flip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ design/arm_cordic_cell.sv @@
// One rotation-mode CORDIC iteration with its own pipeline register.
// The stage index arrives as a tied-off port. Depends on arm_pkg.
`default_nettype none

module arm_cordic_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire [arm_pkg::IDXW-1:0] stage_i,
  input  wire                   valid_i,
  output logic                  ready_o,
  input  arm_pkg::cordic_t      data_i,
  output logic                  valid_o,
  input  wire                   ready_i,
  output arm_pkg::cordic_t      data_o
);
  import arm_pkg::*;

  logic                 valid_q;
  cordic_t              data_d, data_q;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    xs = data_i.x >>> stage_i;
    ys = data_i.y >>> stage_i;
    at = atan_q30(5'(stage_i));
    data_d = data_i;
    if (!data_i.z[ZW-1]) begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - at;
    end else begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ design/arm_matrix.sv @@
// Output stage: rounds cos and sin to Q1.14, applies the fold and places
// them in the matrix for the chosen axis. Depends on arm_pkg.
`default_nettype none

module arm_matrix (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  output logic             ready_o,
  input  arm_pkg::cordic_t data_i,
  output logic             valid_o,
  input  wire              stall_i,
  output arm_pkg::out_t    data_o
);
  import arm_pkg::*;

  logic               valid_q;
  out_t               data_d, data_q;
  logic signed [15:0] c, s, ns;

  function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v);
    logic signed [XW:0]    t;
    logic signed [XW-16:0] q;
    t = {v[XW-1], v} + (XW+1)'(32768);
    q = t[XW:16];
    priority if (q > (XW-15)'(16384)) begin
      return ONE_Q14;
    end else if (q < -(XW-15)'(16384)) begin
      return NEG_ONE_Q14;
    end else begin
      return q[15:0];
    end
  endfunction

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    c  = to_q14(data_i.x);
    s  = to_q14(data_i.y);
    if (data_i.flip) begin
      c = -c;
      s = -s;
    end
    ns = -s;
    data_d = '{ONE_Q14, ZERO_Q14, ZERO_Q14,
               ZERO_Q14, ONE_Q14, ZERO_Q14,
               ZERO_Q14, ZERO_Q14, ONE_Q14};
    unique case (data_i.cmd)
      CMD_X: begin
        data_d.m11 = c;  data_d.m12 = ns;
        data_d.m21 = s;  data_d.m22 = c;
      end
      CMD_Y: begin
        data_d.m00 = c;  data_d.m02 = s;
        data_d.m20 = ns; data_d.m22 = c;
      end
      CMD_Z: begin
        data_d.m00 = c;  data_d.m01 = ns;
        data_d.m10 = s;  data_d.m11 = c;
      end
      CMD_IDENTITY: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ sim/arm_matrix_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for axis_rotation_matrix_unit: predicts the matrix of every accepted
// transaction and compares delivered matrices field by field, in order.
// Depends on arm_pkg.

module arm_matrix_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  arm_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  arm_pkg::out_t out_data_i,
  output int            errors_o,
  output int            pending_o
);
  import arm_pkg::*;

  // Q2.30 angle constants
  localparam longint ANG_HALF_PI = 64'sd1686629713;
  localparam longint ANG_PI      = 64'sd3373259426;
  localparam longint ANG_TWO_PI  = 64'sd6746518852;
  localparam longint CORDIC_K    = 64'sd652032874;

  // atan(2^-i) in Q2.30, truncated
  localparam longint ATAN_TBL [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  localparam string FIELD_NAME [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                       "m20", "m21", "m22"};

  typedef struct {
    in_t  src;
    out_t mat;
  } matrix_entry_t;

  matrix_entry_t matrix_q [$];
  matrix_entry_t want;
  logic [143:0]  want_bits, got_bits;
  int            fail_cnt = 0;
  int            k;

  // Q2.30 to Q1.14, round half up, saturate to +-1.0
  function automatic logic signed [15:0] q30_to_q14(input longint v);
    longint q;
    q = (v + 64'sd32768) >>> 16;
    if (q > longint'(ONE_Q14)) q = longint'(ONE_Q14);
    if (q < longint'(NEG_ONE_Q14)) q = longint'(NEG_ONE_Q14);
    return q[15:0];
  endfunction

  function automatic void cordic_cos_sin(input  logic signed [15:0] angle,
                                         output logic signed [15:0] c,
                                         output logic signed [15:0] s);
    longint z, x, y, nx;
    bit     flip;
    int     i;
    z    = longint'(angle) * 64'sd262144;
    x    = CORDIC_K;
    y    = 0;
    flip = 1'b0;
    if (z > ANG_PI) z -= ANG_TWO_PI;
    else if (z < -ANG_PI) z += ANG_TWO_PI;
    // outside +-pi/2: rotate by pi and negate afterwards
    if (z > ANG_HALF_PI) begin
      z -= ANG_PI;
      flip = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z += ANG_PI;
      flip = 1'b1;
    end
    for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_TBL[i];
      end
      x = nx;
    end
    c = q30_to_q14(x);
    s = q30_to_q14(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic out_t rotation_matrix(input in_t t);
    out_t              m;
    logic signed [15:0] c, s;
    m.m00 = ONE_Q14;  m.m01 = ZERO_Q14; m.m02 = ZERO_Q14;
    m.m10 = ZERO_Q14; m.m11 = ONE_Q14;  m.m12 = ZERO_Q14;
    m.m20 = ZERO_Q14; m.m21 = ZERO_Q14; m.m22 = ONE_Q14;
    cordic_cos_sin(t.angle, c, s);
    case (t.cmd)
      CMD_X: begin
        m.m11 = c; m.m12 = -s; m.m21 = s; m.m22 = c;
      end
      CMD_Y: begin
        m.m00 = c; m.m02 = s; m.m20 = -s; m.m22 = c;
      end
      CMD_Z: begin
        m.m00 = c; m.m01 = -s; m.m10 = s; m.m11 = c;
      end
      default: ;
    endcase
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        want.src = in_data_i;
        want.mat = rotation_matrix(in_data_i);
        matrix_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (matrix_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result, nothing outstanding", $realtime);
        end else begin
          want      = matrix_q.pop_front();
          want_bits = want.mat;
          got_bits  = out_data_i;
          for (k = 0; k < 9; k++) begin
            if (got_bits[143-16*k -: 16] !== want_bits[143-16*k -: 16]) begin
              fail_cnt++;
              if (fail_cnt <= 10)
                $display("%0t: cmd %0d angle %0d: %s expected %0d got %0d", $realtime,
                         want.src.cmd, want.src.angle, FIELD_NAME[k],
                         $signed(want_bits[143-16*k -: 16]),
                         $signed(got_bits[143-16*k -: 16]));
            end
          end
        end
      end
      errors_o  <= fail_cnt;
      pending_o <= matrix_q.size();
    end
  end

endmodule

@@ sim/tb_axis_rotation_matrix_unit.sv @@
`timescale 1ns / 100ps
// Top-level testbench for axis_rotation_matrix_unit: clock, reset, stimulus and
// verdict. Depends on arm_pkg, arm_matrix_checker and the unit itself.

module tb_axis_rotation_matrix_unit;
  import arm_pkg::*;

  localparam int LATENCY          = CORDIC_STAGES + 2;
  localparam int CYCLE_LIMIT      = 200000;   // watchdog bound on the run length, in cycles
  localparam int RANDOM_PER_PHASE = 434;
  localparam int ANG_MAX          = 25736;    // 2 pi in Q3.12

  localparam logic [1:0] AXES [4] = '{CMD_X, CMD_Y, CMD_Z, CMD_IDENTITY};

  // Directed angles: zero, the range ends, either side of the pi/2 fold and
  // of the pi wrap, pi/4, and the smallest negative step.
  localparam int DIRECTED_ANGLES [11] = '{0, ANG_MAX, -ANG_MAX, 6433, 6434, -6434,
                                          12867, 12868, -12868, 3217, -1};
  // pi/2, pi and 2 pi in Q3.12; random angles cluster round these
  localparam int FOLD_POINTS [3] = '{6434, 12868, 25736};

  // idle percentages per phase: sender, receiver
  localparam int SEND_IDLE [3]  = '{6, 67, 0};
  localparam int RECV_STALL [3] = '{67, 6, 0};

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_stall_i;
  out_t  out_data_o;

  int    errors;
  int    pending;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    cycles;

  axis_rotation_matrix_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  arm_matrix_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // 4 ns period
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver back-pressure; the rate follows the current phase. Stall does
  // not look at valid, so gaps land on every pipeline phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic in_t make_item(input logic [1:0] cmd, input int angle);
    in_t t;
    t.cmd   = cmd;
    t.angle = 16'(angle);
    return t;
  endfunction

  // Mostly uniform over +-2 pi; the rest sits within a few LSBs of a fold or
  // wrap point, where the range reduction has to pick the right branch.
  function automatic in_t random_item();
    int a;
    int bound;
    if ($urandom_range(0, 9) < 7) begin
      a = int'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
    end else begin
      bound = FOLD_POINTS[$urandom_range(0, 2)] + int'($urandom_range(0, 6)) - 3;
      if (bound > ANG_MAX) bound = ANG_MAX;
      a = $urandom_range(0, 1) ? bound : -bound;
    end
    return make_item(AXES[$urandom_range(0, 3)], a);
  endfunction

  // Present one transaction and hold it until accepted. A sender gap lowers
  // valid first, so valid is never dropped and raised in the same step.
  // Each cycle idles with the phase's percentage.
  task automatic send_transaction(input in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold the sender off until every outstanding matrix has been delivered.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    int idx;
    int ph;
    int n;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each special angle under two different axis codes, so every
    // axis and the identity see the folds and the wrap; the range ends go to Y, Z and the identity.
    for (idx = 0; idx < 11; idx++) begin
      send_transaction(make_item(AXES[idx % 4], DIRECTED_ANGLES[idx]));
      send_transaction(make_item(AXES[(idx + 1) % 4], DIRECTED_ANGLES[idx]));
    end
    drain_pipeline();

    // Random phases: sender-light / receiver-heavy, the reverse, then flat out.
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct  <= SEND_IDLE[ph];
      recv_stall_pct <= RECV_STALL[ph];
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_transaction(random_item());
        if (ph == 0 && n == RANDOM_PER_PHASE / 2)
          drain_pipeline();
      end
    end

    drain_pipeline();
    repeat (LATENCY + 8) @(posedge clk_i);

    if (errors == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
